@@ rtl/logistic_prox_newton_defines.svh @@
// Assertion macros shared by the logistic prox Newton checker.
`ifndef LOGISTIC_PROX_NEWTON_DEFINES_SVH
`define LOGISTIC_PROX_NEWTON_DEFINES_SVH

// Clocked assertion with an active-low reset that disables it.
`define LPN_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Same, on the block's own clock and reset names.
`define LPN_ASSERT_STD(lbl, prop, msg) `LPN_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

@@ rtl/lpn_pkg.sv @@
// Package with types, constants and arithmetic helpers of the logistic prox Newton block.
`timescale 1ns / 1ps
`default_nettype none
package lpn_pkg;

  localparam int FRAC_BITS = 24;
  localparam logic [3:0] MAX_STEPS = 4'd15;
  localparam int DIV_W = 64;

  localparam logic signed [31:0] ONE = 32'sd16777216;
  localparam logic signed [31:0] FIVE = 32'sd83886080;
  localparam logic signed [31:0] HALF = 32'sd8388608;
  localparam logic signed [31:0] TENTH = 32'sd1677722;
  localparam logic signed [32:0] LOG2E_Q30 = 33'sd1549082005;
  localparam logic signed [32:0] LN2_Q30 = 33'sd744261118;
  localparam logic [31:0] Q30_ONE = 32'h4000_0000;

  localparam logic [30:0] POW2_TBL [16] = '{
    31'd1073741824, 31'd1028218693, 31'd984625594, 31'd942880698,
    31'd902905651, 31'd864625413, 31'd827968132, 31'd792865000,
    31'd759250125, 31'd727060410, 31'd696235434, 31'd666717338,
    31'd638450708, 31'd611382493, 31'd585461881, 31'd560640219
  };

  typedef enum logic {
    REG_TAU   = 1'b0,
    REG_STEPS = 1'b1
  } cfg_idx_e;

  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD, OP_LO_DIV, OP_LO_FIN, OP_MUL_TA, OP_MID_NUM, OP_QDIV,
    OP_MID_FIN, OP_HI, OP_ABS, OP_M_LOG, OP_Y, OP_M_LN, OP_T, OP_M_T2, OP_T2,
    OP_M_T3, OP_T3, OP_P, OP_M_E, OP_E, OP_S_DIV, OP_S, OP_M_V, OP_V, OP_M_TD,
    OP_NUM, OP_UPD, OP_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } cmd_t;

  typedef struct packed {
    logic lo;
    logic mid;
    logic den_zero;
    logic div_busy;
  } stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -66'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [65:0] rnd30(input logic signed [65:0] v);
    return (v + 66'sd536870912) >>> 30;
  endfunction

  function automatic logic signed [65:0] rnd24(input logic signed [65:0] v);
    return (v + 66'sd8388608) >>> FRAC_BITS;
  endfunction

  // Quotient carries one extra fraction bit; round half away and saturate.
  function automatic logic signed [31:0] div_fin(input logic [DIV_W-1:0] q,
                                                 input logic neg);
    logic [32:0] qr;
    if (q >= 64'h0000_0000_FFFF_FFFF) begin
      return neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    qr = ({1'b0, q[31:0]} + 33'd1) >> 1;
    return neg ? -$signed(qr[31:0]) : $signed(qr[31:0]);
  endfunction

endpackage
`default_nettype wire

@@ rtl/lpn_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module lpn_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        busy_o,
  output logic [63:0] quo_o
);
  import lpn_pkg::*;

  logic              busy_q, busy_d;
  logic [5:0]        cnt_q, cnt_d;
  logic [DIV_W-1:0]  quo_q, quo_d;
  logic [31:0]       rem_q, rem_d;
  logic [31:0]       dsr_q, dsr_d;
  logic [32:0]       rem_sh;
  logic [32:0]       rem_sub;

  assign rem_sh  = {rem_q, quo_q[DIV_W-1]};
  assign rem_sub = rem_sh - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 6'd63;
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      if (!rem_sub[32]) begin
        rem_d = rem_sub[31:0];
        quo_d = {quo_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[31:0];
        quo_d = {quo_q[DIV_W-2:0], 1'b0};
      end
      if (cnt_q == 6'd0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule
`default_nettype wire

@@ rtl/lpn_dp.sv @@
// Datapath: operand registers, shared multiplier, exp and Newton arithmetic, divider.
`timescale 1ns / 1ps
`default_nettype none
module lpn_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lpn_pkg::cmd_t       cmd_i,
  output lpn_pkg::stat_t      stat_o,
  input  logic [30:0]         tau_i,
  input  logic signed [31:0]  alpha_i,
  output logic signed [31:0]  beta_o
);
  import lpn_pkg::*;

  logic signed [31:0] alpha_q, beta_q, d_q, num_q, den_q, out_q;
  logic signed [31:0] alpha_d, beta_d, d_d, num_d, den_d, out_d;
  logic [31:0]        x_q, x_d;
  logic               neg_q, neg_d, dneg_q, dneg_d, kz_q, kz_d;
  logic [4:0]         k_q, k_d;
  logic [23:0]        fr_q, fr_d;
  logic [26:0]        t_q, t_d;
  logic [21:0]        t2_q, t2_d;
  logic [16:0]        t3_q, t3_d;
  logic [30:0]        pp_q, pp_d, e_q, e_d, s_q, s_d;
  logic [28:0]        v_q, v_d;
  logic signed [65:0] p_q, prod, r30, r24;
  logic signed [32:0] mul_a, mul_b;
  logic               div_start, div_busy;
  logic [63:0]        div_dvd, div_quo;
  logic [31:0]        div_dsr, den32, un, ptmp, sw, vw;
  logic [32:0]        yv;
  logic [8:0]         kk;
  logic [33:0]        d6;
  logic [30:0]        e0;
  logic signed [31:0] m;

  lpn_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .busy_o     (div_busy),
    .quo_o      (div_quo)
  );

  assign prod = mul_a * mul_b;
  assign r30  = rnd30(p_q);
  assign r24  = rnd24(p_q);
  assign den32 = Q30_ONE + 32'(e_q);
  assign un   = num_q[31] ? (~num_q + 32'd1) : num_q;
  assign yv   = r30[32:0];
  assign kk   = yv[32:24];
  assign d6   = (34'(t3_q) * 34'd43691) >> 18;
  assign ptmp = Q30_ONE - 32'(t_q) + 32'(t2_q >> 1) - d6[31:0];
  assign e0   = r30[30:0];
  assign m    = sat32(r24);
  assign sw   = (32'(s_q) + 32'd32) >> 6;
  assign vw   = (32'(v_q) + 32'd32) >> 6;

  always_comb begin
    alpha_d = alpha_q; beta_d = beta_q; d_d = d_q; num_d = num_q; den_d = den_q;
    out_d = out_q; x_d = x_q; neg_d = neg_q; dneg_d = dneg_q; kz_d = kz_q;
    k_d = k_q; fr_d = fr_q; t_d = t_q; t2_d = t2_q; t3_d = t3_q; pp_d = pp_q;
    e_d = e_q; s_d = s_q; v_d = v_q;
    mul_a = '0; mul_b = '0;
    div_start = 1'b0; div_dvd = '0; div_dsr = '0;
    case (cmd_i.op)
      OP_LOAD: alpha_d = alpha_i;
      OP_LO_DIV: begin
        div_start = 1'b1;
        div_dvd   = 64'(ONE) << 25;
        div_dsr   = 32'(tau_i);
        dneg_d    = 1'b0;
      end
      OP_LO_FIN: beta_d = sat32(66'(alpha_q) + 66'(div_fin(div_quo, dneg_q)));
      OP_MUL_TA: begin
        mul_a = $signed(33'(tau_i));
        mul_b = 33'(alpha_q);
      end
      OP_MID_NUM: begin
        num_d = sat32(66'(HALF) + 66'(m));
        den_d = sat32($signed(66'(tau_i)) + 66'(TENTH));
      end
      OP_QDIV: begin
        div_start = 1'b1;
        div_dvd   = {7'd0, un, 25'd0};
        div_dsr   = den_q;
        dneg_d    = num_q[31];
      end
      OP_MID_FIN: beta_d = div_fin(div_quo, dneg_q);
      OP_HI: beta_d = alpha_q;
      OP_ABS: begin
        neg_d = beta_q[31];
        x_d   = beta_q[31] ? (~beta_q + 32'd1) : beta_q;
      end
      OP_M_LOG: begin
        mul_a = $signed(33'(x_q));
        mul_b = LOG2E_Q30;
      end
      OP_Y: begin
        kz_d = (kk >= 9'd31);
        k_d  = kk[4:0];
        fr_d = yv[23:0];
      end
      OP_M_LN: begin
        mul_a = $signed(33'({fr_q[19:0], 6'd0}));
        mul_b = LN2_Q30;
      end
      OP_T: t_d = r30[26:0];
      OP_M_T2: begin
        mul_a = $signed(33'(t_q));
        mul_b = $signed(33'(t_q));
      end
      OP_T2: t2_d = r30[21:0];
      OP_M_T3: begin
        mul_a = $signed(33'(t2_q));
        mul_b = $signed(33'(t_q));
      end
      OP_T3: t3_d = r30[16:0];
      OP_P: pp_d = ptmp[30:0];
      OP_M_E: begin
        mul_a = $signed(33'(POW2_TBL[fr_q[23:20]]));
        mul_b = $signed(33'(pp_q));
      end
      OP_E: e_d = kz_q ? '0 : (e0 >> k_q);
      OP_S_DIV: begin
        div_start = 1'b1;
        div_dvd   = (neg_q ? (64'd1 << 60) : {3'd0, e_q, 30'd0}) + 64'(den32 >> 1);
        div_dsr   = den32;
      end
      OP_S: s_d = div_quo[30:0];
      OP_M_V: begin
        mul_a = $signed(33'(s_q));
        mul_b = $signed(33'(Q30_ONE - 32'(s_q)));
      end
      OP_V: begin
        v_d = r30[28:0];
        d_d = sat32(66'(alpha_q) - 66'(beta_q));
      end
      OP_M_TD: begin
        mul_a = $signed(33'(tau_i));
        mul_b = 33'(d_q);
      end
      OP_NUM: begin
        num_d = sat32($signed(66'(sw)) + 66'(m));
        den_d = sat32($signed(66'(vw)) + $signed(66'(tau_i)));
      end
      OP_UPD: beta_d = sat32(66'(beta_q) + 66'(div_fin(div_quo, dneg_q)));
      OP_OUT: out_d = beta_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    p_q <= prod;
    alpha_q <= alpha_d; beta_q <= beta_d; d_q <= d_d; num_q <= num_d; den_q <= den_d;
    out_q <= out_d; x_q <= x_d; neg_q <= neg_d; dneg_q <= dneg_d; kz_q <= kz_d;
    k_q <= k_d; fr_q <= fr_d; t_q <= t_d; t2_q <= t2_d; t3_q <= t3_d; pp_q <= pp_d;
    e_q <= e_d; s_q <= s_d; v_q <= v_d;
  end

  assign stat_o.lo       = (alpha_q < -FIVE);
  assign stat_o.mid      = (alpha_q < FIVE);
  assign stat_o.den_zero = (den_q == 32'sd0);
  assign stat_o.div_busy = div_busy;
  assign beta_o          = out_q;

endmodule
`default_nettype wire

@@ rtl/lpn_ctrl.sv @@
// Controller state machine: sequences the guess, the Newton steps and the output request.
`timescale 1ns / 1ps
`default_nettype none
module lpn_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [3:0]     steps_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  lpn_pkg::stat_t stat_i,
  output lpn_pkg::cmd_t  cmd_o
);
  import lpn_pkg::*;

  typedef enum logic [34:0] {
    ST_IDLE = 35'd1 << 0,  ST_SEL = 35'd1 << 1,  ST_LO_DIV = 35'd1 << 2,
    ST_LO_WAIT = 35'd1 << 3,  ST_LO_FIN = 35'd1 << 4,  ST_MID_MUL = 35'd1 << 5,
    ST_MID_NUM = 35'd1 << 6,  ST_MID_DIV = 35'd1 << 7,  ST_MID_WAIT = 35'd1 << 8,
    ST_MID_FIN = 35'd1 << 9,  ST_HI = 35'd1 << 10,  ST_LOOP = 35'd1 << 11,
    ST_ABS = 35'd1 << 12,  ST_M_LOG = 35'd1 << 13,  ST_Y = 35'd1 << 14,
    ST_M_LN = 35'd1 << 15,  ST_T = 35'd1 << 16,  ST_M_T2 = 35'd1 << 17,
    ST_T2 = 35'd1 << 18,  ST_M_T3 = 35'd1 << 19,  ST_T3 = 35'd1 << 20,
    ST_P = 35'd1 << 21,  ST_M_E = 35'd1 << 22,  ST_E = 35'd1 << 23,
    ST_S_DIV = 35'd1 << 24,  ST_S_WAIT = 35'd1 << 25,  ST_S_FIN = 35'd1 << 26,
    ST_M_V = 35'd1 << 27,  ST_V = 35'd1 << 28,  ST_M_TD = 35'd1 << 29,
    ST_NUM = 35'd1 << 30,  ST_N_DIV = 35'd1 << 31,  ST_N_WAIT = 35'd1 << 32,
    ST_UPD = 35'd1 << 33,  ST_DONE = 35'd1 << 34
  } state_e;

  state_e     state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic       valid_q, valid_d;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    valid_d   = valid_q;
    cmd_o.op  = OP_NOP;
    if (valid_q && out_ready_i) valid_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          cnt_d    = (steps_i > MAX_STEPS) ? MAX_STEPS : steps_i;
          state_d  = ST_SEL;
        end
      end
      ST_SEL: begin
        if (stat_i.lo) state_d = ST_LO_DIV;
        else if (stat_i.mid) state_d = ST_MID_MUL;
        else state_d = ST_HI;
      end
      ST_LO_DIV: begin cmd_o.op = OP_LO_DIV; state_d = ST_LO_WAIT; end
      ST_LO_WAIT: if (!stat_i.div_busy) state_d = ST_LO_FIN;
      ST_LO_FIN: begin cmd_o.op = OP_LO_FIN; state_d = ST_LOOP; end
      ST_MID_MUL: begin cmd_o.op = OP_MUL_TA; state_d = ST_MID_NUM; end
      ST_MID_NUM: begin cmd_o.op = OP_MID_NUM; state_d = ST_MID_DIV; end
      ST_MID_DIV: begin cmd_o.op = OP_QDIV; state_d = ST_MID_WAIT; end
      ST_MID_WAIT: if (!stat_i.div_busy) state_d = ST_MID_FIN;
      ST_MID_FIN: begin cmd_o.op = OP_MID_FIN; state_d = ST_LOOP; end
      ST_HI: begin cmd_o.op = OP_HI; state_d = ST_LOOP; end
      ST_LOOP: begin
        if (cnt_q == 4'd0) begin
          state_d = ST_DONE;
        end else begin
          cnt_d   = cnt_q - 4'd1;
          state_d = ST_ABS;
        end
      end
      ST_ABS: begin cmd_o.op = OP_ABS; state_d = ST_M_LOG; end
      ST_M_LOG: begin cmd_o.op = OP_M_LOG; state_d = ST_Y; end
      ST_Y: begin cmd_o.op = OP_Y; state_d = ST_M_LN; end
      ST_M_LN: begin cmd_o.op = OP_M_LN; state_d = ST_T; end
      ST_T: begin cmd_o.op = OP_T; state_d = ST_M_T2; end
      ST_M_T2: begin cmd_o.op = OP_M_T2; state_d = ST_T2; end
      ST_T2: begin cmd_o.op = OP_T2; state_d = ST_M_T3; end
      ST_M_T3: begin cmd_o.op = OP_M_T3; state_d = ST_T3; end
      ST_T3: begin cmd_o.op = OP_T3; state_d = ST_P; end
      ST_P: begin cmd_o.op = OP_P; state_d = ST_M_E; end
      ST_M_E: begin cmd_o.op = OP_M_E; state_d = ST_E; end
      ST_E: begin cmd_o.op = OP_E; state_d = ST_S_DIV; end
      ST_S_DIV: begin cmd_o.op = OP_S_DIV; state_d = ST_S_WAIT; end
      ST_S_WAIT: if (!stat_i.div_busy) state_d = ST_S_FIN;
      ST_S_FIN: begin cmd_o.op = OP_S; state_d = ST_M_V; end
      ST_M_V: begin cmd_o.op = OP_M_V; state_d = ST_V; end
      ST_V: begin cmd_o.op = OP_V; state_d = ST_M_TD; end
      ST_M_TD: begin cmd_o.op = OP_M_TD; state_d = ST_NUM; end
      ST_NUM: begin cmd_o.op = OP_NUM; state_d = ST_N_DIV; end
      ST_N_DIV: begin
        if (stat_i.den_zero) begin
          state_d = ST_LOOP;
        end else begin
          cmd_o.op = OP_QDIV;
          state_d  = ST_N_WAIT;
        end
      end
      ST_N_WAIT: if (!stat_i.div_busy) state_d = ST_UPD;
      ST_UPD: begin cmd_o.op = OP_UPD; state_d = ST_LOOP; end
      ST_DONE: begin
        if (!valid_q || out_ready_i) begin
          cmd_o.op = OP_OUT;
          valid_d  = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = valid_q;

endmodule
`default_nettype wire

@@ rtl/logistic_prox_newton.sv @@
// Top level of the logistic proximal operator with Newton refinement.
//
//   Channel   Dir  Fields (low bit first)         Handshake
//   s_axis    in   tdata[31:0] alpha              s_axis_tvalid / s_axis_tready
//   m_axis    out  tdata[31:0] beta               m_axis_tvalid / m_axis_tready
//   cfg       in   idx 0 tau, idx 1 newton_steps  cfg_we_i
//
// One sample at a time. The guess is a single move at or above 5 and a divider pass otherwise,
// and each Newton step makes two passes of the shared divider, the second skipped on a zero denominator.
// Reset is asynchronous, active low, and restores tau = 1.0 and four Newton steps.
// A new request is taken while the previous result still waits on m_axis.
`timescale 1ns / 1ps
`default_nettype none
module logistic_prox_newton (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // alpha[31:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // beta[31:0]
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [30:0] cfg_wdata_i
);
  import lpn_pkg::*;

  logic [30:0]        tau_q;
  logic [3:0]         steps_q;
  cmd_t               cmd;
  stat_t              stat;
  logic signed [31:0] beta;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tau_q   <= 31'd16777216;
      steps_q <= 4'd4;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        REG_TAU:   tau_q   <= cfg_wdata_i;
        REG_STEPS: steps_q <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  lpn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .steps_i     (steps_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  lpn_dp u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .stat_o  (stat),
    .tau_i   (tau_q),
    .alpha_i ($signed(s_axis_tdata)),
    .beta_o  (beta)
  );

  assign m_axis_tdata = beta;

endmodule
`default_nettype wire

@@ rtl/lpn_checker.sv @@
// Port-level checker for the logistic prox Newton block, with its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "logistic_prox_newton_defines.svh"
module lpn_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  `LPN_ASSERT_STD(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped")
  `LPN_ASSERT_STD(a_out_stable, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "result changed")
  `LPN_ASSERT_STD(a_busy_after_take, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "second request taken")
  `LPN_ASSERT_STD(a_idle_on_result, $rose(m_axis_tvalid) |-> s_axis_tready, "not idle after result")

endmodule

bind logistic_prox_newton lpn_checker u_lpn_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

@@ tb/tb.sv @@
// Self-checking bench for the logistic prox Newton block: directed table, then random samples.
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import lpn_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // alpha[31:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // beta[31:0]
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [30:0] cfg_wdata_i;

  logistic_prox_newton DUT (.*);

  typedef struct {
    logic [31:0] alpha;
    logic        known;
    logic [31:0] beta;
  } row_t;

  longint      tau_q;
  int unsigned steps_q;
  logic [31:0] beta_fifo[$];
  int          errors;
  int          idle_cycles;
  logic        stalls_on;

  const longint POW2_NEG[16] = '{
    1073741824, 1028218693, 984625594, 942880698, 902905651, 864625413,
    827968132, 792865000, 759250125, 727060410, 696235434, 666717338,
    638450708, 611382493, 585461881, 560640219
  };

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint round_shift(longint x, int k);
    if (k == 0) return x;
    x += longint'(1) << (k - 1);
    return x >>> k;
  endfunction

  function automatic longint rounded_quotient(longint num, longint den);
    logic        neg, over;
    longint unsigned un, ud, q, r;
    if (den <= 0) return num > 0 ? 64'sd2147483647 : (num < 0 ? -64'sd2147483648 : 0);
    neg = num < 0;
    un = neg ? -num : num;
    ud = den;
    q = un / ud;
    r = un % ud;
    over = q > 64'hFFFF_FFFF;
    for (int i = 0; i <= FRAC_BITS && !over; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= ud) begin
        r -= ud;
        q |= 1;
      end
      if (q > (64'd1 << 34)) over = 1'b1;
    end
    if (over) q = 64'd1 << 32;
    else q = (q + 1) >> 1;
    if (neg) return q >= (64'd1 << 31) ? -64'sd2147483648 : -longint'(q);
    return q > 64'd2147483647 ? 64'sd2147483647 : longint'(q);
  endfunction

  function automatic longint exp_neg(longint x);
    longint y, k, fr, f30, b, t, t2, t3, p, e;
    y = round_shift(x * 64'sd1549082005, 30);
    k = y >>> FRAC_BITS;
    if (k >= 31) return 0;
    fr = y - (k << FRAC_BITS);
    f30 = fr << (30 - FRAC_BITS);
    b = f30 & 64'h3FF_FFFF;
    t = round_shift(b * 64'sd744261118, 30);
    t2 = round_shift(t * t, 30);
    t3 = round_shift(t2 * t, 30);
    p = (longint'(1) << 30) - t + t2 / 2 - t3 / 6;
    e = round_shift(POW2_NEG[(f30 >> 26) & 15] * p, 30);
    return e >>> k;
  endfunction

  function automatic longint sigmoid_q30(longint b);
    longint unsigned e, den, numr;
    if (b >= 0) begin
      e = exp_neg(b);
      numr = e << 30;
    end else begin
      e = exp_neg(-b);
      numr = 64'd1 << 60;
    end
    den = (64'd1 << 30) + e;
    return longint'((numr + den / 2) / den);
  endfunction

  function automatic logic [31:0] prox_point(logic [31:0] alpha_bits);
    longint one, five, alpha, b, m, num, den, s, v, d;
    int unsigned n;
    one = longint'(1) << FRAC_BITS;
    five = 5 * one;
    alpha = longint'($signed(alpha_bits));
    n = steps_q < 15 ? steps_q : 15;
    if (alpha < -five) begin
      b = clamp32(alpha + rounded_quotient(one, tau_q));
    end else if (alpha < five) begin
      m = clamp32(round_shift(tau_q * alpha, FRAC_BITS));
      num = clamp32((one >> 1) + m);
      den = clamp32(tau_q + (one + 5) / 10);
      b = rounded_quotient(num, den);
    end else begin
      b = alpha;
    end
    for (int unsigned j = 0; j < n; j++) begin
      s = sigmoid_q30(b);
      v = round_shift(s * ((longint'(1) << 30) - s), 30);
      d = clamp32(alpha - b);
      m = clamp32(round_shift(tau_q * d, FRAC_BITS));
      num = clamp32(round_shift(s, 6) + m);
      den = clamp32(round_shift(v, 6) + tau_q);
      if (den > 0) b = clamp32(b + rounded_quotient(num, den));
    end
    return b[31:0];
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [30:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_TAU) tau_q = value;
    else steps_q = value[3:0];
  endtask

  task automatic drain();
    while (beta_fifo.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic random_gap();
    int g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    repeat (g) @(posedge clk_i);
  endtask

  // The request is dropped after its handshake, before the next one can be raised.
  task automatic send_alpha(logic [31:0] a, logic gaps);
    if (gaps) random_gap();
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= a;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    s_axis_tvalid <= 1'b0;
    beta_fifo.push_back(prox_point(a));
    @(posedge clk_i);
  endtask

  // Result side: random back-pressure once stalls are on, and compare against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (beta_fifo.size() == 0) begin
          $display("%0t: unexpected result, actual %h", $time, m_axis_tdata);
          errors++;
        end else begin
          if (beta_fifo[0] !== m_axis_tdata) begin
            $display("%0t: beta mismatch, expected %h actual %h", $time, beta_fifo[0],
                     m_axis_tdata);
            errors++;
          end
          void'(beta_fifo.pop_front());
        end
      end
      if (!stalls_on) m_axis_tready <= 1'b1;
      else if ($urandom_range(0, 19) == 0) m_axis_tready <= ~m_axis_tready;
      else if (!m_axis_tready && $urandom_range(0, 2) == 0) m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    row_t rows[$];
    logic [31:0] a;
    int sel;
    errors = 0;
    idle_cycles = 0;
    stalls_on = 1'b0;
    tau_q = 16777216;
    steps_q = 4;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b1;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_TAU;
    cfg_wdata_i = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // At or above the upper knee with zero steps the sample passes through unchanged.
    write_reg(REG_STEPS, 4'd0);
    rows = '{'{32'h7FFF_FFFF, 1, 32'h7FFF_FFFF}, '{32'h0500_0000, 1, 32'h0500_0000},
             '{32'h1234_5678, 1, 32'h1234_5678}};
    foreach (rows[i]) begin
      send_alpha(rows[i].alpha, 1'b0);
      if (rows[i].known) beta_fifo[$] = rows[i].beta;
    end
    drain();
    write_reg(REG_STEPS, 4'd4);
    write_reg(REG_TAU, 31'd16777216);
    rows = '{'{32'h8000_0000, 0, 0}, '{32'hFB00_0000, 0, 0}, '{32'hFAFF_FFFF, 0, 0},
             '{32'h04FF_FFFF, 0, 0}, '{32'h0000_0000, 0, 0}, '{32'hFFFF_FFFF, 0, 0},
             '{32'h0100_0000, 0, 0}, '{32'h7FFF_FFFF, 0, 0}};
    foreach (rows[i]) send_alpha(rows[i].alpha, 1'b0);
    drain();
    write_reg(REG_TAU, 31'd1);
    write_reg(REG_STEPS, 4'd15);
    foreach (rows[i]) send_alpha(rows[i].alpha, 1'b0);
    drain();
    write_reg(REG_TAU, 31'h7FFF_FFFF);
    foreach (rows[i]) send_alpha(rows[i].alpha, 1'b0);
    drain();

    stalls_on = 1'b1;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: write_reg(REG_TAU, 31'($urandom_range(1 << 20, 1 << 27)));
        1: write_reg(REG_TAU, 31'($urandom()));
        2: write_reg(REG_TAU, 31'($urandom_range(1, 255)));
        default: write_reg(REG_TAU, 31'h7FFF_FFFF - 31'($urandom_range(0, 1000)));
      endcase
      write_reg(REG_STEPS, 4'($urandom_range(0, 15)));
      for (int k = 0; k < 250; k++) begin
        sel = $urandom_range(0, 9);
        if (sel < 6) a = $urandom_range(0, 32'h0C00_0000) - 32'h0600_0000;
        else if (sel < 8) a = $urandom();
        else a = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000 + 32'h0500_0000 *
                 ($urandom_range(0, 1) ? 1 : -1);
        send_alpha(a, 1'b1);
        if (k == 100) drain();
      end
      drain();
    end

    drain();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+rtl
rtl/lpn_pkg.sv
rtl/lpn_div.sv
rtl/lpn_dp.sv
rtl/lpn_ctrl.sv
rtl/logistic_prox_newton.sv
rtl/lpn_checker.sv
tb/tb.sv
